FILE: src/ftli_pkg.sv
`default_nettype none

package ftli_pkg;

   // field widths
   localparam int FREQ_W  = 21;
   localparam int DEPTH_W = 15;
   localparam int PCT_W   = 15;
   localparam int VOL_W   = 16;
   localparam int CAP_W   = 8;

   // stream and register port widths
   localparam int REQ_W      = 24;
   localparam int RSP_W      = 48;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_EMPTY_DEPTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_DEPTH      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_USABLE_CAPACITY = 2'd2;

   // register reset values
   localparam logic [DEPTH_W-1:0] EMPTY_DEPTH_RESET     = 15'd2560;
   localparam logic [DEPTH_W-1:0] FULL_DEPTH_RESET      = 15'd20480;
   localparam logic [CAP_W-1:0]   USABLE_CAPACITY_RESET = 8'd83;

   // calibration table
   localparam int ROM_POINTS           = 11;
   localparam int ROM_IDX_W            = 4;
   localparam int TABLE_POINTS_DEFAULT = 11;
   localparam int STEP_Q8              = 2560;
   localparam int PCT_FULL_Q8          = 25600;

   // widest segment span in hertz, and quotient bits of the segment divide
   localparam int SPAN_W = 15;
   localparam int QUO1_W = 12;
   localparam int NUM1_W = SPAN_W + QUO1_W;

   // scaling divide: quotient below 2^16, numerator up to diff*cap*256
   localparam int QUO2_W = 16;
   localparam int NUM2_W = DEPTH_W + CAP_W + 8;

   // calibration frequencies, shallowest point first
   function automatic logic [FREQ_W-1:0] rom_freq(input logic [ROM_IDX_W-1:0] idx);
      case (idx)
         4'd0:    rom_freq = 21'd1942934;
         4'd1:    rom_freq = 21'd1923931;
         4'd2:    rom_freq = 21'd1910090;
         4'd3:    rom_freq = 21'd1896290;
         4'd4:    rom_freq = 21'd1883620;
         4'd5:    rom_freq = 21'd1870067;
         4'd6:    rom_freq = 21'd1857326;
         4'd7:    rom_freq = 21'd1845110;
         4'd8:    rom_freq = 21'd1834063;
         4'd9:    rom_freq = 21'd1822194;
         default: rom_freq = 21'd1809855;
      endcase
   endfunction

endpackage

`default_nettype wire

FILE: src/frequency_to_level_interpolator.sv
`default_nettype none
// Pipeline: a req_ transfer reaches rsp_tvalid through the input register, the
// segment select stage, 12 restoring divide steps, the depth and multiply stages, 16 scaling
// divide steps and the output register.
// Throughput: one item per cycle while the skid register is empty; an output skid register holds one extra result.
// Reset (synchronous, active high) clears all valid bits and loads the register defaults.
module frequency_to_level_interpolator #(
   parameter int TABLE_POINTS = ftli_pkg::TABLE_POINTS_DEFAULT
) (
   input  wire                              clock,
   input  wire                              reset,
   // req_tdata: measured_frequency [20:0], zero fill above
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [ftli_pkg::REQ_W-1:0]       req_tdata,
   // rsp_tdata: depth_q8 [14:0], fill_percent_q8 [29:15], volume_q8 [45:30], zero fill above
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [ftli_pkg::RSP_W-1:0]       rsp_tdata,
   input  wire                              csr_valid,
   output logic                             csr_ready,
   input  wire  [ftli_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire  [ftli_pkg::CSR_DATA_W-1:0]  csr_data
);
   import ftli_pkg::*;

   localparam int POINT_COUNT = (TABLE_POINTS < 2) ? 2 :
                                (TABLE_POINTS > ROM_POINTS) ? ROM_POINTS : TABLE_POINTS;
   localparam int SEG_W       = (POINT_COUNT > 2) ? $clog2(POINT_COUNT - 1) : 1;
   localparam int DIV1_STEPS  = QUO1_W;
   localparam int DIV2_STEPS  = QUO2_W;
   localparam int PAD_W       = RSP_W - DEPTH_W - PCT_W - VOL_W;

   typedef struct packed {
      logic              clamp_zero;
      logic              clamp_last;
      logic [SEG_W-1:0]  seg;
      logic [SPAN_W-1:0] den;
      logic [NUM1_W-1:0] rem;
      logic [QUO1_W-1:0] quo;
   } div1_type;

   typedef struct packed {
      logic               le_empty;
      logic               ge_full;
      logic [DEPTH_W-1:0] depth;
      logic [CAP_W-1:0]   cap;
      logic [DEPTH_W-1:0] den;
      logic [NUM2_W-1:0]  rem_p;
      logic [NUM2_W-1:0]  rem_v;
      logic [QUO2_W-1:0]  quo_p;
      logic [QUO2_W-1:0]  quo_v;
   } div2_type;

   // configuration registers
   logic [DEPTH_W-1:0] empty_ff;
   logic [DEPTH_W-1:0] full_ff;
   logic [CAP_W-1:0]   cap_ff;

   // pipeline enable: stall only while the skid register is occupied
   logic en;

   // stage registers and valid bits
   logic [FREQ_W-1:0]     freq_ff;
   logic                  v_in_ff;
   div1_type              front_ff;
   div1_type              front_in;
   logic                  v_front_ff;
   div1_type              d1_ff    [DIV1_STEPS];
   div1_type              d1_in    [DIV1_STEPS];
   div1_type              d1_src   [DIV1_STEPS];
   logic [NUM1_W-1:0]     d1_trial [DIV1_STEPS];
   logic [DIV1_STEPS-1:0] v_d1_ff;
   logic [DEPTH_W-1:0]    depth_ff;
   logic [DEPTH_W-1:0]    depth_in;
   logic                  v_depth_ff;
   div2_type              mul_ff;
   div2_type              mul_in;
   logic                  v_mul_ff;
   div2_type              d2_ff    [DIV2_STEPS];
   div2_type              d2_in    [DIV2_STEPS];
   div2_type              d2_src   [DIV2_STEPS];
   logic [NUM2_W-1:0]     d2_trial [DIV2_STEPS];
   logic [DIV2_STEPS-1:0] v_d2_ff;

   // output and skid registers
   logic                  rsp_valid_ff;
   logic [RSP_W-1:0]      rsp_data_ff;
   logic                  skid_valid_ff;
   logic [RSP_W-1:0]      skid_data_ff;
   logic [RSP_W-1:0]      out_in;

   // front-end helpers
   logic [SEG_W-1:0]              seg_v;
   logic [FREQ_W-1:0]             hi_v;
   logic [FREQ_W-1:0]             lo_v;
   logic [DEPTH_W-1:0]            diff_v;
   logic [DEPTH_W+CAP_W-1:0]      vol_prod_v;
   logic [PCT_W-1:0]              pct_v;
   logic [VOL_W-1:0]              vol_v;

   assign en         = !skid_valid_ff;
   assign req_tready = en;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= EMPTY_DEPTH_RESET;
         full_ff  <= FULL_DEPTH_RESET;
         cap_ff   <= USABLE_CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_EMPTY_DEPTH:     empty_ff <= csr_data[DEPTH_W-1:0];
            CSR_FULL_DEPTH:      full_ff  <= csr_data[DEPTH_W-1:0];
            CSR_USABLE_CAPACITY: cap_ff   <= csr_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   // pick the segment: the first point at or below the reading closes it
   always_comb begin
      seg_v = SEG_W'(POINT_COUNT - 2);
      for (int i = POINT_COUNT - 2; i >= 0; i--) begin
         if (freq_ff >= rom_freq(ROM_IDX_W'(i + 1))) seg_v = SEG_W'(i);
      end
      hi_v = rom_freq(ROM_IDX_W'(seg_v));
      lo_v = rom_freq(ROM_IDX_W'(seg_v) + 1'b1);
      front_in.clamp_zero = freq_ff >= rom_freq('0);
      front_in.clamp_last = freq_ff <= rom_freq(ROM_IDX_W'(POINT_COUNT - 1));
      front_in.seg        = seg_v;
      front_in.den        = SPAN_W'(hi_v - lo_v);
      front_in.rem        = NUM1_W'(SPAN_W'(hi_v - freq_ff)) * NUM1_W'(STEP_Q8);
      front_in.quo        = '0;
   end

   // chain the divide stages
   for (genvar s = 0; s < DIV1_STEPS; s++) begin : g_d1_src
      if (s == 0) begin : g_first
         assign d1_src[s] = front_ff;
      end else begin : g_next
         assign d1_src[s] = d1_ff[s-1];
      end
   end

   for (genvar s = 0; s < DIV2_STEPS; s++) begin : g_d2_src
      if (s == 0) begin : g_first
         assign d2_src[s] = mul_ff;
      end else begin : g_next
         assign d2_src[s] = d2_ff[s-1];
      end
   end

   // one restoring step per stage on the segment offset
   always_comb begin
      for (int s = 0; s < DIV1_STEPS; s++) begin
         d1_trial[s] = NUM1_W'(d1_src[s].den) << (QUO1_W - 1 - s);
         d1_in[s]    = d1_src[s];
         if (d1_src[s].rem >= d1_trial[s]) begin
            d1_in[s].rem                = d1_src[s].rem - d1_trial[s];
            d1_in[s].quo[QUO1_W - 1 - s] = 1'b1;
         end
      end
   end

   // form the depth, clamping at either end of the table
   always_comb begin
      if (d1_ff[DIV1_STEPS-1].clamp_zero) begin
         depth_in = '0;
      end else if (d1_ff[DIV1_STEPS-1].clamp_last) begin
         depth_in = DEPTH_W'((POINT_COUNT - 1) * STEP_Q8);
      end else begin
         depth_in = DEPTH_W'(d1_ff[DIV1_STEPS-1].seg) * DEPTH_W'(STEP_Q8)
                  + DEPTH_W'(d1_ff[DIV1_STEPS-1].quo);
      end
   end

   // compare against the limits and build both scaling numerators
   always_comb begin
      diff_v          = depth_ff - empty_ff;
      vol_prod_v      = (DEPTH_W+CAP_W)'(diff_v) * (DEPTH_W+CAP_W)'(cap_ff);
      mul_in.le_empty = depth_ff <= empty_ff;
      mul_in.ge_full  = depth_ff >= full_ff;
      mul_in.depth    = depth_ff;
      mul_in.cap      = cap_ff;
      mul_in.den      = full_ff - empty_ff;
      mul_in.rem_p    = NUM2_W'(diff_v) * NUM2_W'(PCT_FULL_Q8);
      mul_in.rem_v    = {vol_prod_v, 8'b0};
      mul_in.quo_p    = '0;
      mul_in.quo_v    = '0;
   end

   // one restoring step per stage on both scaling lanes
   always_comb begin
      for (int s = 0; s < DIV2_STEPS; s++) begin
         d2_trial[s] = NUM2_W'(d2_src[s].den) << (QUO2_W - 1 - s);
         d2_in[s]    = d2_src[s];
         if (d2_src[s].rem_p >= d2_trial[s]) begin
            d2_in[s].rem_p                = d2_src[s].rem_p - d2_trial[s];
            d2_in[s].quo_p[QUO2_W - 1 - s] = 1'b1;
         end
         if (d2_src[s].rem_v >= d2_trial[s]) begin
            d2_in[s].rem_v                = d2_src[s].rem_v - d2_trial[s];
            d2_in[s].quo_v[QUO2_W - 1 - s] = 1'b1;
         end
      end
   end

   // apply the empty and full limits and pack the result
   always_comb begin
      if (d2_ff[DIV2_STEPS-1].le_empty) begin
         pct_v = '0;
         vol_v = '0;
      end else if (d2_ff[DIV2_STEPS-1].ge_full) begin
         pct_v = PCT_W'(PCT_FULL_Q8);
         vol_v = {d2_ff[DIV2_STEPS-1].cap, 8'b0};
      end else begin
         pct_v = d2_ff[DIV2_STEPS-1].quo_p[PCT_W-1:0];
         vol_v = d2_ff[DIV2_STEPS-1].quo_v[VOL_W-1:0];
      end
      out_in = {{PAD_W{1'b0}}, vol_v, pct_v, d2_ff[DIV2_STEPS-1].depth};
   end

   // advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff    <= 1'b0;
         v_front_ff <= 1'b0;
         v_d1_ff    <= '0;
         v_depth_ff <= 1'b0;
         v_mul_ff   <= 1'b0;
         v_d2_ff    <= '0;
      end else if (en) begin
         v_in_ff    <= req_tvalid;
         v_front_ff <= v_in_ff;
         v_d1_ff    <= {v_d1_ff[DIV1_STEPS-2:0], v_front_ff};
         v_depth_ff <= v_d1_ff[DIV1_STEPS-1];
         v_mul_ff   <= v_depth_ff;
         v_d2_ff    <= {v_d2_ff[DIV2_STEPS-2:0], v_mul_ff};
      end
   end

   // advance the payload
   always_ff @(posedge clock) begin
      if (en) begin
         freq_ff  <= req_tdata[FREQ_W-1:0];
         front_ff <= front_in;
         for (int s = 0; s < DIV1_STEPS; s++) d1_ff[s] <= d1_in[s];
         depth_ff <= depth_in;
         mul_ff   <= mul_in;
         for (int s = 0; s < DIV2_STEPS; s++) d2_ff[s] <= d2_in[s];
      end
   end

   // output register with skid: catch a result while the output is held
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_tready) begin
         rsp_valid_ff  <= skid_valid_ff || v_d2_ff[DIV2_STEPS-1];
         skid_valid_ff <= 1'b0;
      end else if (en && v_d2_ff[DIV2_STEPS-1]) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_tready) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : out_in;
      end else if (en) begin
         skid_data_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

FILE: bench/tb_frequency_to_level_interpolator.sv
`default_nettype none

module tb_frequency_to_level_interpolator;
   import ftli_pkg::*;

   localparam int CLK_PERIOD  = 12;
   localparam int RESET_CYCLES = 12;
   localparam int LAST_POINT  = ROM_POINTS - 1;
   localparam int DRAIN_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 2'd3;

   // calibration frequencies, shallowest point first
   localparam logic [0:ROM_POINTS-1][FREQ_W-1:0] CAL_FREQ = {
      21'd1942934, 21'd1923931, 21'd1910090, 21'd1896290, 21'd1883620, 21'd1870067,
      21'd1857326, 21'd1845110, 21'd1834063, 21'd1822194, 21'd1809855
   };

   // one result, laid out as in rsp_tdata from the lowest bit up
   typedef struct packed {
      logic [VOL_W-1:0]   volume;
      logic [PCT_W-1:0]   percent;
      logic [DEPTH_W-1:0] depth;
   } level_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   wire                   req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   wire                   rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   wire  [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid = 1'b0;
   wire                   csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // register copies kept alongside the block
   logic [DEPTH_W-1:0] empty_depth_copy = EMPTY_DEPTH_RESET;
   logic [DEPTH_W-1:0] full_depth_copy  = FULL_DEPTH_RESET;
   logic [CAP_W-1:0]   capacity_copy    = USABLE_CAPACITY_RESET;

   level_type pending_levels[$];
   int unsigned mismatch_count = 0;
   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;

   frequency_to_level_interpolator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // measured_frequency [20:0], zero fill above
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // depth_q8 [14:0], fill_percent_q8 [29:15], volume_q8 [45:30]
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #(CLK_PERIOD / 2) clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #(CLK_PERIOD * 300000);
      $display("tb_frequency_to_level_interpolator: FAIL");
      $finish;
   end

   // scale a depth between the empty and full marks onto 0 .. top
   function automatic int unsigned scale_fill(input int unsigned depth, input int unsigned top);
      longint unsigned num;
      if (depth <= empty_depth_copy) return 0;
      if (depth >= full_depth_copy) return top;
      num = longint'(depth - empty_depth_copy) * top;
      return int'(num / (full_depth_copy - empty_depth_copy));
   endfunction

   // work out depth, percentage and volume for one frequency reading
   function automatic level_type predict_level(input logic [FREQ_W-1:0] freq);
      int unsigned depth;
      longint unsigned num;
      bit found;
      level_type lvl;
      depth = 0;
      found = 0;
      if (freq >= CAL_FREQ[0]) begin
         depth = 0;
      end else if (freq <= CAL_FREQ[LAST_POINT]) begin
         depth = LAST_POINT * STEP_Q8;
      end else begin
         for (int i = 0; i < LAST_POINT; i++) begin
            if (!found && freq <= CAL_FREQ[i] && freq >= CAL_FREQ[i+1]) begin
               num = longint'(CAL_FREQ[i] - freq) * STEP_Q8;
               depth = i * STEP_Q8 + int'(num / (CAL_FREQ[i] - CAL_FREQ[i+1]));
               found = 1;
            end
         end
      end
      lvl.depth   = depth[DEPTH_W-1:0];
      lvl.percent = PCT_W'(scale_fill(depth, PCT_FULL_Q8));
      lvl.volume  = VOL_W'(scale_fill(depth, int'(capacity_copy) * 256));
      return lvl;
   endfunction

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // watch all three channels: check results, queue predictions, track registers
   always @(posedge clock) begin
      level_type want;
      level_type got;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(level_type)-1:0];
            if (pending_levels.size() == 0) begin
               report_mismatch("result with nothing pending, depth_q8", -1, got.depth);
            end else begin
               want = pending_levels.pop_front();
               if (got.depth !== want.depth)
                  report_mismatch("depth_q8", want.depth, got.depth);
               if (got.percent !== want.percent)
                  report_mismatch("fill_percent_q8", want.percent, got.percent);
               if (got.volume !== want.volume)
                  report_mismatch("volume_q8", want.volume, got.volume);
            end
            if (rsp_tdata[RSP_W-1:$bits(level_type)] !== '0)
               report_mismatch("rsp_tdata fill bits", 0, rsp_tdata[RSP_W-1:$bits(level_type)]);
         end
         if (req_tvalid && req_tready)
            pending_levels.push_back(predict_level(req_tdata[FREQ_W-1:0]));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_EMPTY_DEPTH:     empty_depth_copy = csr_data[DEPTH_W-1:0];
               CSR_FULL_DEPTH:      full_depth_copy  = csr_data[DEPTH_W-1:0];
               CSR_USABLE_CAPACITY: capacity_copy    = csr_data[CAP_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // stall the result side at the current rate
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // send one reading, idling first at the current rate; leaves tvalid high
   task automatic send_reading(input logic [FREQ_W-1:0] freq);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W-FREQ_W){1'b0}}, freq};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // drop tvalid and wait for every pending result
   task automatic wait_drained();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (pending_levels.size() != 0) begin
         report_mismatch("results never arrived, count", 0, pending_levels.size());
         pending_levels.delete();
      end
   endtask

   // write one register while the block is idle
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_thresholds(input logic [CSR_DATA_W-1:0] empty_mark,
                                 input logic [CSR_DATA_W-1:0] full_mark,
                                 input logic [CSR_DATA_W-1:0] capacity);
      write_register(CSR_EMPTY_DEPTH, empty_mark);
      write_register(CSR_FULL_DEPTH, full_mark);
      write_register(CSR_USABLE_CAPACITY, capacity);
   endtask

   // points, their neighbours and the clamp edges
   task automatic sweep_calibration_points();
      send_reading('0);
      send_reading({FREQ_W{1'b1}});
      send_reading(FREQ_W'(CAL_FREQ[0] + 1));
      send_reading(CAL_FREQ[0]);
      send_reading(FREQ_W'(CAL_FREQ[0] - 1));
      for (int i = 1; i < LAST_POINT; i++)
         send_reading(CAL_FREQ[i]);
      send_reading(FREQ_W'(CAL_FREQ[LAST_POINT] + 1));
      send_reading(CAL_FREQ[LAST_POINT]);
      send_reading(FREQ_W'(CAL_FREQ[LAST_POINT] - 1));
      send_reading(FREQ_W'((CAL_FREQ[0] + CAL_FREQ[1]) / 2));
      send_reading(FREQ_W'((CAL_FREQ[4] + CAL_FREQ[5]) / 2));
      send_reading(FREQ_W'((CAL_FREQ[9] + CAL_FREQ[10]) / 2));
      send_reading(FREQ_W'(CAL_FREQ[5] - 1));
      wait_drained();
   endtask

   // mostly inside the table, some near the points, some anywhere in the field
   function automatic logic [FREQ_W-1:0] random_reading();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 75)
         return FREQ_W'($urandom_range(CAL_FREQ[0] + 300, CAL_FREQ[LAST_POINT] - 300));
      if (pick < 87)
         return FREQ_W'(CAL_FREQ[$urandom_range(LAST_POINT)] + $urandom_range(4) - 2);
      return FREQ_W'($urandom);
   endfunction

   task automatic random_thresholds();
      int unsigned pick;
      logic [CSR_DATA_W-1:0] lo;
      logic [CSR_DATA_W-1:0] hi;
      pick = $urandom_range(9);
      lo = CSR_DATA_W'($urandom_range(LAST_POINT * STEP_Q8));
      hi = CSR_DATA_W'($urandom_range(LAST_POINT * STEP_Q8));
      if (pick < 6) begin
         // ordinary window, empty below full
         if (lo > hi) set_thresholds(hi, lo, CSR_DATA_W'($urandom_range(255)));
         else set_thresholds(lo, hi, CSR_DATA_W'($urandom_range(255)));
      end else if (pick < 8) begin
         set_thresholds(lo, hi, CSR_DATA_W'($urandom));
      end else begin
         set_thresholds(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom));
      end
   endtask

   task automatic test_default_registers();
      sweep_calibration_points();
   endtask

   task automatic test_register_extremes();
      // widest window and largest tank
      set_thresholds('0, CSR_DATA_W'(LAST_POINT * STEP_Q8), CSR_DATA_W'(255));
      sweep_calibration_points();
      // full mark below empty mark, zero capacity
      set_thresholds(CSR_DATA_W'(LAST_POINT * STEP_Q8), '0, '0);
      sweep_calibration_points();
      // equal marks
      set_thresholds(16'd12800, 16'd12800, 16'd100);
      sweep_calibration_points();
      // all data bits set, then an index that maps to no register
      set_thresholds({CSR_DATA_W{1'b1}}, {CSR_DATA_W{1'b1}}, {CSR_DATA_W{1'b1}});
      write_register(CSR_UNUSED_INDEX, 16'h0000);
      write_register(CSR_UNUSED_INDEX, {CSR_DATA_W{1'b1}});
      sweep_calibration_points();
      set_thresholds(CSR_DATA_W'(EMPTY_DEPTH_RESET), CSR_DATA_W'(FULL_DEPTH_RESET),
                     CSR_DATA_W'(USABLE_CAPACITY_RESET));
   endtask

   task automatic test_random_readings(input int unsigned idle_pct, input int unsigned stall_pct);
      sender_idle_pct = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int blk = 0; blk < 3; blk++) begin
         random_thresholds();
         for (int n = 0; n < 88; n++)
            send_reading(random_reading());
      end
      wait_drained();
   endtask

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      sender_idle_pct = 24;
      receiver_stall_pct = 65;
      test_default_registers();
      test_register_extremes();
      test_random_readings(24, 65);
      test_random_readings(65, 24);
      test_random_readings(0, 0);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_frequency_to_level_interpolator: PASS");
      end else begin
         $display("tb_frequency_to_level_interpolator: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
